### hdl/pip_pkg.sv
// Package for the point-in-polygon crossing test block.
// Holds widths, mode and status codes, and the queue entry type. No dependencies.
`timescale 1ns / 1ps
`default_nettype none
package pip_pkg;
  localparam int MaxVertices = 64;
  localparam int AddrW       = $clog2(MaxVertices);
  localparam int CntW        = $clog2(MaxVertices + 1);
  localparam int CoordW      = 16;
  localparam int OffW        = 12;
  localparam int CrossW      = 7;
  localparam logic [OffW-1:0] OffsetReset = 12'd160;

  typedef enum logic [1:0] {
    MODE_APPEND = 2'd0,
    MODE_QUERY  = 2'd1,
    MODE_CLEAR  = 2'd2,
    MODE_NONE   = 2'd3
  } mode_e;

  typedef enum logic [1:0] {
    ST_OK    = 2'd0,
    ST_EMPTY = 2'd1,
    ST_FULL  = 2'd2
  } status_e;

  typedef enum logic [1:0] {
    BK_IDLE,
    BK_WALK,
    BK_DRAIN,
    BK_OUT
  } back_state_e;

  // Work handed from the front part to the back part.
  typedef struct packed {
    logic                     walk;
    status_e                  status;
    logic [CntW-1:0]          count;
    logic signed [CoordW:0]   ex;
    logic signed [CoordW:0]   ey;
    logic signed [CoordW-1:0] qx;
    logic signed [CoordW-1:0] qy;
  } job_t;
endpackage
`default_nettype wire

### hdl/pip_in_if.sv
// Input channel: valid/ready handshake with mode and coordinates.
// Depends on pip_pkg.
`timescale 1ns / 1ps
`default_nettype none
interface pip_in_if import pip_pkg::*;;
  logic                     valid;
  logic                     ready;
  logic [1:0]               mode;
  logic signed [CoordW-1:0] x;
  logic signed [CoordW-1:0] y;
  modport source (output valid, mode, x, y, input ready);
  modport sink   (input valid, mode, x, y, output ready);
endinterface
`default_nettype wire

### hdl/pip_out_if.sv
// Result channel: valid/ready handshake with status, parity and crossing count.
// Depends on pip_pkg.
`timescale 1ns / 1ps
`default_nettype none
interface pip_out_if import pip_pkg::*;;
  logic              valid;
  logic              ready;
  logic [1:0]        status;
  logic              inside_res;
  logic [CrossW-1:0] crossings;
  modport source (output valid, status, inside_res, crossings, input ready);
  modport sink   (input valid, status, inside_res, crossings, output ready);
endinterface
`default_nettype wire

### hdl/point_in_polygon_crossing_test_top.sv
// Channel   Dir  Payload
// in_if     in   mode, x, y
// out_if    out  status, inside_res, crossings
// cfg       in   ray_offset_we_i, ray_offset_i (12 bit)
// An append, clear or empty query passes through the queue to the back part,
// which presents its result without a walk. A query makes count + 1 vertex
// store reads at one per cycle, then goes through the registered store read,
// the two-stage product pipeline and the drain state before its result.
// Appends wait until a query's result is taken, since they write the store.
// The two-entry queue lets the front accept while a result waits on out_if.
// Reset clears count, leftmost vertex, the queue and the walker state.
// Depends on pip_pkg, the interfaces, pip_ram, pip_front, pip_queue, pip_back.
`timescale 1ns / 1ps
`default_nettype none
module point_in_polygon_crossing_test_top import pip_pkg::*; (
  input  wire logic            clk_i,
  input  wire logic            rst_ni,
  input  wire logic            ray_offset_we_i,
  input  wire logic [OffW-1:0] ray_offset_i,
  pip_in_if.sink               in_if,
  pip_out_if.source            out_if
);
  logic [OffW-1:0] offset_q;
  logic            fj_valid, fj_ready, bj_valid, bj_ready;
  job_t            fjob, bjob;
  logic            walk_done;
  logic            we;
  logic [AddrW-1:0] waddr, raddr;
  logic [2*CoordW-1:0] wdata, rdata;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      offset_q <= OffsetReset;
    end else if (ray_offset_we_i) begin
      offset_q <= ray_offset_i;
    end
  end

  pip_front u_front (
    .clk_i, .rst_ni, .offset_i(offset_q), .in_if,
    .job_valid_o(fj_valid), .job_ready_i(fj_ready), .job_o(fjob),
    .walk_done_i(walk_done),
    .we_o(we), .waddr_o(waddr), .wdata_o(wdata)
  );

  pip_queue u_queue (
    .clk_i, .rst_ni,
    .push_valid_i(fj_valid), .push_ready_o(fj_ready), .push_i(fjob),
    .pop_valid_o(bj_valid), .pop_ready_i(bj_ready), .pop_o(bjob)
  );

  pip_ram #(.Width(2*CoordW), .Depth(MaxVertices)) u_ram (
    .clk_i, .we_i(we), .waddr_i(waddr), .wdata_i(wdata),
    .raddr_i(raddr), .rdata_o(rdata)
  );

  pip_back u_back (
    .clk_i, .rst_ni,
    .job_valid_i(bj_valid), .job_ready_o(bj_ready), .job_i(bjob),
    .walk_done_o(walk_done),
    .raddr_o(raddr), .rdata_i(rdata), .out_if
  );
endmodule
`default_nettype wire

### hdl/pip_ram.sv
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none
module pip_ram #(
  parameter int Width = 32,
  parameter int Depth = 64
) (
  input  wire logic                     clk_i,
  input  wire logic                     we_i,
  input  wire logic [$clog2(Depth)-1:0] waddr_i,
  input  wire logic [Width-1:0]         wdata_i,
  input  wire logic [$clog2(Depth)-1:0] raddr_i,
  output logic      [Width-1:0]         rdata_o
);
  logic [Width-1:0] mem_q [Depth];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_o <= mem_q[raddr_i];
  end
endmodule
`default_nettype wire

### hdl/pip_front.sv
// Front part: accepts transactions, keeps count and leftmost vertex, writes
// the vertex store and issues jobs to the queue. Depends on pip_pkg.
`timescale 1ns / 1ps
`default_nettype none
module pip_front import pip_pkg::*; (
  input  wire logic       clk_i,
  input  wire logic       rst_ni,
  input  wire logic [OffW-1:0] offset_i,
  pip_in_if.sink          in_if,
  output logic            job_valid_o,
  input  wire logic       job_ready_i,
  output job_t            job_o,
  input  wire logic       walk_done_i,
  output logic            we_o,
  output logic [AddrW-1:0] waddr_o,
  output logic [2*CoordW-1:0] wdata_o
);
  logic [CntW-1:0]          count_q, count_d;
  logic signed [CoordW-1:0] lx_q, lx_d, ly_q, ly_d;
  logic [1:0]               pend_q, pend_d;
  logic                     acc;
  logic                     full;
  logic                     append_hold;

  // An append may overwrite a vertex that a queued or running query still
  // has to read, so appends wait until no query is outstanding.
  assign append_hold = (mode_e'(in_if.mode) == MODE_APPEND) && !full && (pend_q != 2'd0);
  assign in_if.ready = job_ready_i && !append_hold;
  assign job_valid_o = in_if.valid && !append_hold;
  assign acc         = in_if.valid && in_if.ready;
  assign full        = (count_q == CntW'(MaxVertices));
  assign waddr_o     = count_q[AddrW-1:0];
  assign wdata_o     = {in_if.y, in_if.x};
  assign we_o        = acc && (mode_e'(in_if.mode) == MODE_APPEND) && !full;
  assign pend_d      = pend_q + {1'b0, acc && job_o.walk} - {1'b0, walk_done_i};

  always_comb begin
    count_d = count_q;
    lx_d    = lx_q;
    ly_d    = ly_q;
    job_o.walk   = 1'b0;
    job_o.status = ST_OK;
    job_o.count  = count_q;
    job_o.ex     = {lx_q[CoordW-1], lx_q} - $signed({1'b0, offset_i});
    job_o.ey     = {ly_q[CoordW-1], ly_q} - $signed({1'b0, offset_i});
    job_o.qx     = in_if.x;
    job_o.qy     = in_if.y;
    unique case (mode_e'(in_if.mode))
      MODE_APPEND: begin
        if (full) begin
          job_o.status = ST_FULL;
        end else if (acc) begin
          count_d = count_q + 1'b1;
          if (count_q == '0 || in_if.x < lx_q) begin
            lx_d = in_if.x;
            ly_d = in_if.y;
          end
        end
      end
      MODE_QUERY: begin
        if (count_q == '0) begin
          job_o.status = ST_EMPTY;
        end else begin
          job_o.walk = 1'b1;
        end
      end
      MODE_CLEAR: begin
        if (acc) begin
          count_d = '0;
          lx_d    = '0;
          ly_d    = '0;
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q <= '0;
      lx_q    <= '0;
      ly_q    <= '0;
      pend_q  <= '0;
    end else begin
      count_q <= count_d;
      lx_q    <= lx_d;
      ly_q    <= ly_d;
      pend_q  <= pend_d;
    end
  end

  assert property (@(posedge clk_i) disable iff (!rst_ni) count_q <= CntW'(MaxVertices))
    else $error("vertex count beyond capacity");
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    we_o |=> count_q == $past(count_q) + 1'b1)
    else $error("store write without count step");
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    job_o.walk |-> job_o.count != '0)
    else $error("walk issued on empty polygon");
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    we_o |-> pend_q == 2'd0)
    else $error("store written while a query is outstanding");
endmodule
`default_nettype wire

### hdl/pip_queue.sv
// Two-entry job queue between front and back parts.
// Depends on pip_pkg.
`timescale 1ns / 1ps
`default_nettype none
module pip_queue import pip_pkg::*; (
  input  wire logic clk_i,
  input  wire logic rst_ni,
  input  wire logic push_valid_i,
  output logic      push_ready_o,
  input  job_t      push_i,
  output logic      pop_valid_o,
  input  wire logic pop_ready_i,
  output job_t      pop_o
);
  job_t       mem_q [2];
  logic       wp_q, rp_q;
  logic [1:0] fill_q;
  logic       push, pop;

  assign push_ready_o = (fill_q != 2'd2);
  assign pop_valid_o  = (fill_q != 2'd0);
  assign pop_o        = mem_q[rp_q];
  assign push = push_valid_i && push_ready_o;
  assign pop  = pop_valid_o && pop_ready_i;

  always_ff @(posedge clk_i) begin
    if (push) begin
      mem_q[wp_q] <= push_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wp_q   <= 1'b0;
      rp_q   <= 1'b0;
      fill_q <= '0;
    end else begin
      if (push) wp_q <= ~wp_q;
      if (pop)  rp_q <= ~rp_q;
      fill_q <= fill_q + {1'b0, push} - {1'b0, pop};
    end
  end

  assert property (@(posedge clk_i) disable iff (!rst_ni) fill_q != 2'd3)
    else $error("queue fill out of range");
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (push && !pop) |=> fill_q == $past(fill_q) + 2'd1)
    else $error("queue fill did not grow on push");
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (fill_q == 2'd2) |-> (wp_q == rp_q))
    else $error("queue pointers disagree when full");
endmodule
`default_nettype wire

### hdl/pip_back.sv
// Back part: walks the polygon edges one per cycle through a product
// pipeline and counts crossings. Depends on pip_pkg.
`timescale 1ns / 1ps
`default_nettype none
module pip_back import pip_pkg::*; (
  input  wire logic clk_i,
  input  wire logic rst_ni,
  input  wire logic job_valid_i,
  output logic      job_ready_o,
  input  job_t      job_i,
  output logic      walk_done_o,
  output logic [AddrW-1:0] raddr_o,
  input  wire logic [2*CoordW-1:0] rdata_i,
  pip_out_if.source out_if
);
  localparam int DW = CoordW + 2;       // differences of 17-bit values
  localparam int PW = 2 * DW;           // products
  localparam int CW = PW + 1;           // cross products

  back_state_e state_q, state_d;
  job_t        job_q;
  logic [CntW-1:0] idx_q;               // next vertex index to read
  logic            rd_v_q, rd_first_q;  // read data valid next cycle
  logic            dv_q, dfirst_q;      // read data valid on rdata_i now
  logic [2*CoordW-1:0] prev_q;
  logic            s1_v_q, s2_v_q;
  logic [CrossW-1:0] cnt_q;
  logic            par_q;
  logic            last_issued_q;

  // Stage 1 registers: differences.
  logic signed [DW-1:0] dx_q, dy_q, ax_q, ay_q, bx_q, by_q, rx_q, ry_q;
  // Stage 2 registers: products.
  logic signed [PW-1:0] p0_q, p1_q, p2_q, p3_q, p4_q, p5_q, p6_q, p7_q;

  logic signed [CoordW-1:0] p1x, p1y, p2x, p2y;
  logic [2*CoordW-1:0] cur;
  logic signed [CW-1:0] ca, cb, num, den, numa, dena;
  logic hit;

  assign cur = rdata_i;
  assign p1x = prev_q[CoordW-1:0];
  assign p1y = prev_q[2*CoordW-1:CoordW];
  assign p2x = cur[CoordW-1:0];
  assign p2y = cur[2*CoordW-1:CoordW];
  assign raddr_o = idx_q[AddrW-1:0];

  always_ff @(posedge clk_i) begin
    if (state_q == BK_IDLE) job_q <= job_i;
    if (dv_q) begin
      prev_q <= cur;
      dx_q <= DW'(p2x) - DW'(p1x);
      dy_q <= DW'(p2y) - DW'(p1y);
      ax_q <= DW'(job_q.ex) - DW'(p1x);
      ay_q <= DW'(job_q.ey) - DW'(p1y);
      bx_q <= DW'(job_q.qx) - DW'(p1x);
      by_q <= DW'(job_q.qy) - DW'(p1y);
      rx_q <= DW'(job_q.qx) - DW'(job_q.ex);
      ry_q <= DW'(job_q.qy) - DW'(job_q.ey);
    end
    p0_q <= dx_q * ay_q;  p1_q <= dy_q * ax_q;
    p2_q <= dx_q * by_q;  p3_q <= dy_q * bx_q;
    p4_q <= ax_q * ry_q;  p5_q <= ay_q * rx_q;
    p6_q <= dx_q * ry_q;  p7_q <= dy_q * rx_q;
  end

  always_comb begin
    ca   = CW'(p0_q) - CW'(p1_q);
    cb   = CW'(p2_q) - CW'(p3_q);
    num  = CW'(p4_q) - CW'(p5_q);
    den  = CW'(p6_q) - CW'(p7_q);
    numa = den[CW-1] ? -num : num;
    dena = den[CW-1] ? -den : den;
    hit  = (ca[CW-1] != cb[CW-1]) && (numa > 0) && (numa < dena);
  end

  // Edge sequence: the first read loads the last vertex as "previous";
  // reads of vertex 0..n-1 then each form one edge with the previous one.
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      BK_IDLE:  if (job_valid_i) state_d = job_i.walk ? BK_WALK : BK_OUT;
      BK_WALK:  if (last_issued_q) state_d = BK_DRAIN;
      BK_DRAIN: if (!rd_v_q && !dv_q && !s1_v_q && !s2_v_q) state_d = BK_OUT;
      BK_OUT:   if (out_if.ready) state_d = BK_IDLE;
      default:  state_d = BK_IDLE;
    endcase
  end

  assign job_ready_o = (state_q == BK_IDLE);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= BK_IDLE;
      idx_q <= '0;
      rd_v_q <= 1'b0;
      rd_first_q <= 1'b0;
      dv_q <= 1'b0;
      dfirst_q <= 1'b0;
      s1_v_q <= 1'b0;
      s2_v_q <= 1'b0;
      cnt_q <= '0;
      par_q <= 1'b0;
      last_issued_q <= 1'b0;
    end else begin
      state_q <= state_d;
      dv_q     <= rd_v_q;
      dfirst_q <= rd_first_q;
      s2_v_q  <= s1_v_q;
      s1_v_q  <= dv_q && !dfirst_q;
      if (state_q == BK_IDLE) begin
        idx_q <= job_i.count - 1'b1;
        rd_v_q <= job_valid_i && job_i.walk;
        rd_first_q <= job_valid_i && job_i.walk;
        last_issued_q <= 1'b0;
        cnt_q <= '0;
        par_q <= 1'b0;
      end else if (state_q == BK_WALK && !last_issued_q) begin
        rd_first_q <= 1'b0;
        if (rd_first_q) begin
          idx_q <= '0;
          rd_v_q <= 1'b1;
          last_issued_q <= (job_q.count == CntW'(1));
        end else begin
          idx_q <= idx_q + 1'b1;
          rd_v_q <= 1'b1;
          last_issued_q <= (idx_q + 1'b1 == job_q.count - 1'b1);
        end
      end else begin
        rd_v_q <= 1'b0;
        rd_first_q <= 1'b0;
      end
      if (s2_v_q && hit) begin
        cnt_q <= cnt_q + 1'b1;
        par_q <= ~par_q;
      end
    end
  end

  assign out_if.valid      = (state_q == BK_OUT);
  assign out_if.status     = job_q.status;
  assign out_if.inside_res = job_q.walk ? par_q : 1'b0;
  assign out_if.crossings  = job_q.walk ? cnt_q : '0;
  assign walk_done_o       = out_if.valid && out_if.ready && job_q.walk;

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == BK_OUT && !out_if.ready) |=> state_q == BK_OUT)
    else $error("result dropped while stalled");
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    s2_v_q |-> state_q == BK_WALK || state_q == BK_DRAIN)
    else $error("edge result outside a walk");
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    cnt_q[0] == par_q)
    else $error("parity and count disagree");
endmodule
`default_nettype wire

### verif/point_in_polygon_crossing_test_top_tb.sv
// Self-checking testbench for point_in_polygon_crossing_test_top.
// It drives vertex loads, clears and queries, predicts each result itself and checks it.
// Depends on pip_pkg, pip_in_if, pip_out_if and the block under test.
`timescale 1ns / 1ps
module point_in_polygon_crossing_test_top_tb;
  import pip_pkg::*;

  typedef struct {
    status_e    status;
    logic       inside_res;
    logic [6:0] crossings;
  } pip_result_t;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic ray_offset_we_i = 1'b0;
  logic [OffW-1:0] ray_offset_i = '0;

  pip_in_if  in_if ();
  pip_out_if out_if ();

  point_in_polygon_crossing_test_top u_top (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .ray_offset_we_i (ray_offset_we_i),
    .ray_offset_i    (ray_offset_i),
    .in_if           (in_if),
    .out_if          (out_if)
  );

  always #10 clk_i = ~clk_i;

  // Predictor state.
  logic signed [15:0] poly_x [MaxVertices];
  logic signed [15:0] poly_y [MaxVertices];
  int unsigned        poly_count = 0;
  logic signed [15:0] left_x = '0;
  logic signed [15:0] left_y = '0;
  logic [OffW-1:0]    offset_shadow = OffsetReset;

  pip_result_t expected_results[$];
  int  error_count = 0;
  bit  in_gaps = 1'b1;
  bit  out_gaps = 1'b1;
  int  hold_off = 0;
  bit  long_stall = 1'b0;
  event long_stall_ev;
  longint cycle_count = 0;

  initial begin
    in_if.valid = 1'b0;
    in_if.mode  = '0;
    in_if.x     = '0;
    in_if.y     = '0;
    out_if.ready = 1'b0;
  end

  function automatic longint cross2(longint ux, longint uy, longint vx, longint vy);
    return ux * vy - uy * vx;
  endfunction

  function automatic bit edge_crossed(int i1, int i2, longint ex, longint ey,
                                      longint qx, longint qy);
    longint dx, dy, ax, ay, bx, by, rx, ry, ca, cb, num, den;
    dx = longint'(poly_x[i2]) - poly_x[i1];
    dy = longint'(poly_y[i2]) - poly_y[i1];
    ax = ex - poly_x[i1];
    ay = ey - poly_y[i1];
    bx = qx - poly_x[i1];
    by = qy - poly_y[i1];
    rx = qx - ex;
    ry = qy - ey;
    ca = cross2(dx, dy, ax, ay);
    cb = cross2(dx, dy, bx, by);
    if ((ca < 0) == (cb < 0)) return 1'b0;
    num = cross2(ax, ay, rx, ry);
    den = cross2(dx, dy, rx, ry);
    if (den < 0) begin
      den = -den;
      num = -num;
    end
    return (num > 0) && (num < den);
  endfunction

  function automatic pip_result_t polygon_step(mode_e mode, logic signed [15:0] x,
                                               logic signed [15:0] y);
    pip_result_t r;
    longint ex, ey;
    int cnt;
    r = '{ST_OK, 1'b0, 7'd0};
    case (mode)
      MODE_APPEND: begin
        if (poly_count >= MaxVertices) begin
          r.status = ST_FULL;
        end else begin
          if (poly_count == 0 || x < left_x) begin
            left_x = x;
            left_y = y;
          end
          poly_x[poly_count] = x;
          poly_y[poly_count] = y;
          poly_count++;
        end
      end
      MODE_QUERY: begin
        if (poly_count == 0) begin
          r.status = ST_EMPTY;
        end else begin
          ex = longint'(left_x) - offset_shadow;
          ey = longint'(left_y) - offset_shadow;
          cnt = 0;
          for (int i = 0; i < poly_count; i++)
            if (edge_crossed((i == 0) ? poly_count - 1 : i - 1, i, ex, ey, x, y)) cnt++;
          r.inside_res = cnt[0];
          r.crossings  = (cnt > 127) ? 7'd127 : cnt[6:0];
        end
      end
      MODE_CLEAR: begin
        poly_count = 0;
        left_x = '0;
        left_y = '0;
      end
      default: ;
    endcase
    return r;
  endfunction

  // Valid stays high between back-to-back calls; it drops before a gap and
  // whenever the sender waits for the block to drain.
  task automatic send_item(mode_e mode, logic signed [15:0] x, logic signed [15:0] y);
    pip_result_t r;
    if (in_gaps && $urandom_range(0, 5) == 0) begin
      in_if.valid <= 1'b0;
      repeat ($urandom_range(1, 14)) @(posedge clk_i);
    end
    in_if.valid <= 1'b1;
    in_if.mode  <= mode;
    in_if.x     <= x;
    in_if.y     <= y;
    do @(posedge clk_i); while (!in_if.ready);
    r = polygon_step(mode, x, y);
    expected_results = {expected_results, r};
  endtask

  task automatic wait_drained();
    in_if.valid <= 1'b0;
    while (expected_results.size() != 0) @(posedge clk_i);
    repeat (10) @(posedge clk_i);
  endtask

  task automatic write_offset(logic [OffW-1:0] value);
    wait_drained();
    ray_offset_we_i <= 1'b1;
    ray_offset_i    <= value;
    @(posedge clk_i);
    ray_offset_we_i <= 1'b0;
    offset_shadow = value;
  endtask

  function automatic logic signed [15:0] rand_coord(int span);
    return 16'($signed($urandom_range(0, 2 * span)) - span);
  endfunction

  // Long receiver stall, counted here while the sender keeps offering.
  always begin
    @(long_stall_ev);
    long_stall <= 1'b1;
    repeat (400) @(posedge clk_i);
    long_stall <= 1'b0;
  end

  // Result checker and receiver stall control.
  always @(posedge clk_i) begin
    pip_result_t e;
    cycle_count <= cycle_count + 1;
    if (out_if.valid && out_if.ready) begin
      if (expected_results.size() == 0) begin
        $error("result transaction with nothing expected");
        error_count++;
      end else begin
        e = expected_results.pop_front();
        if (out_if.status != e.status) begin
          $error("status: expected %0d, actual %0d", e.status, out_if.status);
          error_count++;
        end
        if (out_if.inside_res != e.inside_res) begin
          $error("inside_res: expected %0d, actual %0d", e.inside_res, out_if.inside_res);
          error_count++;
        end
        if (out_if.crossings != e.crossings) begin
          $error("crossings: expected %0d, actual %0d", e.crossings, out_if.crossings);
          error_count++;
        end
      end
    end
    if (!rst_ni) begin
      out_if.ready <= 1'b0;
    end else if (long_stall) begin
      out_if.ready <= 1'b0;
    end else if (hold_off > 0) begin
      hold_off <= hold_off - 1;
      out_if.ready <= 1'b0;
    end else if (out_gaps && $urandom_range(0, 7) == 0) begin
      hold_off <= $urandom_range(0, 13);
      out_if.ready <= 1'b0;
    end else begin
      out_if.ready <= 1'b1;
    end
  end

  always @(posedge clk_i) begin
    if (cycle_count > 1000000) begin
      $display("point_in_polygon_crossing_test_top_tb: FAIL");
      $finish;
    end
  end

  task automatic test_extremes();
    send_item(MODE_QUERY, 16'sd0, 16'sd0);
    send_item(MODE_APPEND, -16'sd32768, 16'sd32767);
    send_item(MODE_QUERY, 16'sd0, 16'sd0);
    send_item(MODE_APPEND, 16'sd32767, 16'sd32767);
    send_item(MODE_APPEND, 16'sd32767, -16'sd32768);
    send_item(MODE_APPEND, -16'sd32768, -16'sd32768);
    send_item(MODE_QUERY, 16'sd0, 16'sd0);
    send_item(MODE_QUERY, 16'sd32767, 16'sd32767);
    send_item(MODE_QUERY, -16'sd32768, -16'sd32768);
    send_item(MODE_NONE, -16'sd1, -16'sd1);
    send_item(MODE_CLEAR, 16'sd5, 16'sd5);
    send_item(MODE_QUERY, 16'sd1, 16'sd1);
    // A single vertex and a repeated vertex give zero-length edges.
    send_item(MODE_APPEND, 16'sd100, 16'sd100);
    send_item(MODE_QUERY, 16'sd100, 16'sd100);
    send_item(MODE_APPEND, 16'sd100, 16'sd100);
    send_item(MODE_APPEND, 16'sd400, 16'sd100);
    send_item(MODE_APPEND, 16'sd400, 16'sd400);
    send_item(MODE_QUERY, 16'sd300, 16'sd200);
    send_item(MODE_QUERY, 16'sd400, 16'sd250);
    send_item(MODE_CLEAR, 16'sd0, 16'sd0);
  endtask

  task automatic test_full_store();
    for (int i = 0; i < MaxVertices + 2; i++)
      send_item(MODE_APPEND, rand_coord(32767), rand_coord(32767));
    for (int i = 0; i < 3; i++)
      send_item(MODE_QUERY, rand_coord(32767), rand_coord(32767));
    send_item(MODE_CLEAR, '0, '0);
  endtask

  task automatic test_offsets();
    logic [OffW-1:0] offs [4] = '{12'd0, 12'd4095, 12'd1, 12'd160};
    foreach (offs[k]) begin
      write_offset(offs[k]);
      send_item(MODE_APPEND, 16'sd0, 16'sd0);
      send_item(MODE_APPEND, 16'sd800, 16'sd0);
      send_item(MODE_APPEND, 16'sd800, 16'sd800);
      send_item(MODE_APPEND, 16'sd0, 16'sd800);
      for (int i = 0; i < 6; i++)
        send_item(MODE_QUERY, rand_coord(1200), rand_coord(1200));
      send_item(MODE_CLEAR, '0, '0);
    end
  endtask

  task automatic test_backpressure();
    wait_drained();
    -> long_stall_ev;
    for (int i = 0; i < 12; i++)
      send_item(MODE_APPEND, rand_coord(500), rand_coord(500));
    send_item(MODE_CLEAR, '0, '0);
  endtask

  // Mostly well-formed polygons with random content, then queries, some noise.
  task automatic test_random(int n_items);
    int sent, nv, span, q;
    sent = 0;
    while (sent < n_items) begin
      if (sent > n_items * 3 / 4) begin
        in_gaps = 1'b0;
        out_gaps = 1'b0;
      end
      if (in_gaps && $urandom_range(0, 9) == 0)
        write_offset(12'($urandom_range(0, 4095)));
      span = ($urandom_range(0, 3) == 0) ? 32767 : $urandom_range(16, 2000);
      nv = ($urandom_range(0, 9) == 0) ? $urandom_range(40, 66) : $urandom_range(1, 10);
      for (int i = 0; i < nv; i++) begin
        send_item(MODE_APPEND, rand_coord(span), rand_coord(span));
        sent++;
      end
      q = $urandom_range(1, 10);
      for (int i = 0; i < q; i++) begin
        if ($urandom_range(0, 9) == 0)
          send_item(mode_e'($urandom_range(0, 3)), rand_coord(32767), rand_coord(32767));
        else
          send_item(MODE_QUERY, rand_coord(span), rand_coord(span));
        sent++;
      end
      send_item(MODE_CLEAR, rand_coord(32767), rand_coord(32767));
      sent++;
    end
  endtask

  initial begin
    repeat (2) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    test_extremes();
    test_full_store();
    test_offsets();
    test_backpressure();
    test_random(1050);
    wait_drained();
    repeat (80) @(posedge clk_i);
    if (error_count == 0) begin
      $display("point_in_polygon_crossing_test_top_tb: PASS");
    end else begin
      $display("point_in_polygon_crossing_test_top_tb: FAIL");
    end
    $finish;
  end
endmodule
